// ----- rtl/tsfd_pkg.sv -----
// Shared types and constants for the three-sensor frame deframer.
// Used by tsfd_decode and three_sensor_frame_deframer; depends on nothing.
package tsfd_pkg;

  // Widths of the frame, the register port and one sensor value
  localparam int FRAME_W    = 8;
  localparam int SENSOR_W   = 12;
  localparam int NUM_SENSOR = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  // Default number of data frames per sequence
  localparam int BITS_PER_SAMPLE_DEF = 12;

  // Frame bit positions: sensor a sits at bit 5 above b and c, parity bits at the bottom
  localparam int SENSOR_A_BIT = 5;
  localparam int PAR_AB_BIT   = 2;
  localparam int PAR_BC_BIT   = 1;
  localparam int PAR_CA_BIT   = 0;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_START_CODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_END_CODE     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SERVICE_MASK = 2'd2;

  // Register values after reset
  localparam logic [CFG_DATA_W-1:0] START_CODE_RST   = 8'd192;
  localparam logic [CFG_DATA_W-1:0] END_CODE_RST     = 8'd64;
  localparam logic [CFG_DATA_W-1:0] SERVICE_MASK_RST = 8'd192;

  typedef enum logic [1:0] {
    CLASS_START = 2'd0,
    CLASS_DATA  = 2'd1,
    CLASS_END   = 2'd2,
    CLASS_ERROR = 2'd3
  } frame_class_t;

  typedef enum logic [1:0] {
    STATUS_BUSY   = 2'd0,
    STATUS_DONE   = 2'd1,
    STATUS_REJECT = 2'd2
  } status_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] start_code;
    logic [CFG_DATA_W-1:0] end_code;
    logic [CFG_DATA_W-1:0] service_mask;
  } cfg_t;

  // Accumulators, index 0 is sensor a
  typedef logic [NUM_SENSOR-1:0][SENSOR_W-1:0] sensor_arr_t;

  // One result, packed lowest field last so it maps straight onto tdata
  typedef struct packed {
    logic [SENSOR_W-1:0] sensor_c;
    logic [SENSOR_W-1:0] sensor_b;
    logic [SENSOR_W-1:0] sensor_a;
    frame_class_t        frame_class;
    status_t             status;
  } result_t;

  localparam int OUT_TDATA_W = $bits(result_t);

endpackage

// ----- rtl/tsfd_decode.sv -----
// Per-frame decode: classifies one frame and computes the next phase,
// accumulators and result. Combinational only; depends on tsfd_pkg.
module tsfd_decode #(
  parameter int BITS_PER_SAMPLE = tsfd_pkg::BITS_PER_SAMPLE_DEF,
  parameter int PHASE_W         = $clog2(BITS_PER_SAMPLE + 2)
) (
  input  logic [tsfd_pkg::FRAME_W-1:0] frame_i,
  input  tsfd_pkg::cfg_t               cfg_i,
  input  logic [PHASE_W-1:0]           phase_i,
  input  tsfd_pkg::sensor_arr_t        acc_i,
  output logic [PHASE_W-1:0]           phase_o,
  output tsfd_pkg::sensor_arr_t        acc_o,
  output tsfd_pkg::result_t            res_o
);
  import tsfd_pkg::*;

  localparam logic [PHASE_W-1:0] PH_IDLE  = '0;
  localparam logic [PHASE_W-1:0] PH_FIRST = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PH_LAST  = PHASE_W'(BITS_PER_SAMPLE);
  localparam logic [PHASE_W-1:0] PH_END   = PHASE_W'(BITS_PER_SAMPLE + 1);

  frame_class_t       cls;
  status_t            status;
  logic [PHASE_W-1:0] phase_eff;
  logic [PHASE_W-1:0] pos;
  logic               sa, sb, sc;

  assign sa = frame_i[SENSOR_A_BIT];
  assign sb = frame_i[SENSOR_A_BIT-1];
  assign sc = frame_i[SENSOR_A_BIT-2];

  // Classify: start beats end, then service bits, then pairwise parity
  always_comb begin
    if (frame_i == cfg_i.start_code) begin
      cls = CLASS_START;
    end else if (frame_i == cfg_i.end_code) begin
      cls = CLASS_END;
    end else if ((frame_i & cfg_i.service_mask) != '0) begin
      cls = CLASS_ERROR;
    end else if ((sa ^ sb) != frame_i[PAR_AB_BIT] ||
                 (sb ^ sc) != frame_i[PAR_BC_BIT] ||
                 (sc ^ sa) != frame_i[PAR_CA_BIT]) begin
      cls = CLASS_ERROR;
    end else begin
      cls = CLASS_DATA;
    end
  end

  // A start frame always restarts the sequence
  assign phase_eff = (cls == CLASS_START) ? PH_IDLE : phase_i;
  assign pos       = phase_eff - PH_FIRST;

  // Advance the phase: clear on start, place one bit per sensor per data frame, check the end frame
  always_comb begin
    phase_o = PH_IDLE;
    acc_o   = acc_i;
    status  = STATUS_REJECT;
    if (phase_eff == PH_IDLE) begin
      if (cls == CLASS_START) begin
        acc_o   = '0;
        phase_o = PH_FIRST;
        status  = STATUS_BUSY;
      end
    end else if (phase_eff <= PH_LAST) begin
      if (cls == CLASS_DATA) begin
        for (int j = 0; j < SENSOR_W; j++) begin
          if (int'(pos) == j) begin
            for (int i = 0; i < NUM_SENSOR; i++) begin
              acc_o[i][j] = acc_i[i][j] | frame_i[SENSOR_A_BIT-i];
            end
          end
        end
        phase_o = phase_eff + PH_FIRST;
        status  = STATUS_BUSY;
      end
    end else if (phase_eff == PH_END) begin
      status = (cls == CLASS_END) ? STATUS_DONE : STATUS_REJECT;
    end
  end

  // Report the accumulators after this frame
  always_comb begin
    res_o.status      = status;
    res_o.frame_class = cls;
    res_o.sensor_a    = acc_o[0];
    res_o.sensor_b    = acc_o[1];
    res_o.sensor_c    = acc_o[2];
  end

endmodule

// ----- rtl/three_sensor_frame_deframer.sv -----
// Top level of the three-sensor frame deframer: configuration registers,
// sequence state and a two-entry output buffer. Depends on tsfd_pkg, tsfd_decode.
//
//   Channel  Direction  Handshake          Payload
//   in_      slave      tvalid / tready    tdata[7:0] frame_byte
//   out_     master     tvalid / tready    tdata[39:0] status, frame_class,
//                                          sensor_a, sensor_b, sensor_c
//   cfg_     write      we (no wait)       addr = register index, wdata[7:0]
//
// One result per frame, one frame per cycle while the skid register is empty;
// each result is registered in the output or skid register. The state update
// is one pass of decode logic into the phase and accumulator registers; in_tready
// depends only on the skid register, so one more frame is taken while a result
// is stalled. Synchronous reset (rst_n low) restores registers and idle phase.
module three_sensor_frame_deframer #(
  parameter int BITS_PER_SAMPLE = tsfd_pkg::BITS_PER_SAMPLE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // frame_byte [7:0]
  input  logic [tsfd_pkg::FRAME_W-1:0]      in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // status [1:0], frame_class [3:2], sensor_a [15:4], sensor_b [27:16],
  // sensor_c [39:28]
  output logic [tsfd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [tsfd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tsfd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tsfd_pkg::*;

  localparam int PHASE_W = $clog2(BITS_PER_SAMPLE + 2);

  cfg_t               cfg_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  sensor_arr_t        acc_r, acc_nxt;
  result_t            res_nxt;
  result_t            out_data_r, skid_data_r;
  logic               out_valid_r, skid_valid_r;
  logic               in_xfer, out_xfer;

  assign in_xfer  = in_tvalid & in_tready;
  assign out_xfer = out_valid_r & out_tready;

  // Write configuration registers; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code   <= START_CODE_RST;
      cfg_r.end_code     <= END_CODE_RST;
      cfg_r.service_mask <= SERVICE_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_START_CODE:   cfg_r.start_code   <= cfg_wdata;
        CFG_END_CODE:     cfg_r.end_code     <= cfg_wdata;
        CFG_SERVICE_MASK: cfg_r.service_mask <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  tsfd_decode #(
    .BITS_PER_SAMPLE (BITS_PER_SAMPLE),
    .PHASE_W         (PHASE_W)
  ) u_decode (
    .frame_i (in_tdata),
    .cfg_i   (cfg_r),
    .phase_i (phase_r),
    .acc_i   (acc_r),
    .phase_o (phase_nxt),
    .acc_o   (acc_nxt),
    .res_o   (res_nxt)
  );

  // Advance sequence state on each input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      acc_r   <= '0;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Output register with skid: hold a new result in the skid stage when stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_xfer) begin
      out_valid_r  <= skid_valid_r | in_xfer;
      skid_valid_r <= 1'b0;
    end else if (in_xfer) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_xfer) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_nxt;
    end
    if (in_xfer && out_valid_r && !out_xfer) begin
      skid_data_r <= res_nxt;
    end
  end

  assign in_tready  = ~skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- test/three_sensor_frame_deframer_tb.sv -----
// Self-checking testbench for the three-sensor frame deframer: drives frames and
// register writes, predicts every result in a scoreboard class and checks the output.
// Depends on tsfd_pkg and three_sensor_frame_deframer.
module three_sensor_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsfd_pkg::*;

  localparam int SEQ_DATA_FRAMES = BITS_PER_SAMPLE_DEF;
  localparam int HOLD_CYCLES     = 200;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int MAX_PRINTED     = 40;

  // Expected-result store and deframer predictor
  class frame_scoreboard;
    logic [CFG_DATA_W-1:0] start_code;
    logic [CFG_DATA_W-1:0] end_code;
    logic [CFG_DATA_W-1:0] service_mask;
    int unsigned           seq_pos;
    logic [SENSOR_W-1:0]   acc [NUM_SENSOR];
    result_t               pending_q [$];
    int                    errors;

    function new();
      start_code   = START_CODE_RST;
      end_code     = END_CODE_RST;
      service_mask = SERVICE_MASK_RST;
      seq_pos      = 0;
      acc          = '{default: '0};
      errors       = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_START_CODE:   start_code = val;
        CFG_END_CODE:     end_code = val;
        CFG_SERVICE_MASK: service_mask = val;
        default: ;
      endcase
    endfunction

    // Start wins over end; data needs clear service bits and matching parity
    function frame_class_t classify(logic [FRAME_W-1:0] f);
      logic a, b, c;
      a = f[SENSOR_A_BIT];
      b = f[SENSOR_A_BIT-1];
      c = f[SENSOR_A_BIT-2];
      if (f == start_code) return CLASS_START;
      if (f == end_code) return CLASS_END;
      if ((f & service_mask) != '0) return CLASS_ERROR;
      if (f[PAR_AB_BIT] != (a ^ b) || f[PAR_BC_BIT] != (b ^ c) || f[PAR_CA_BIT] != (c ^ a))
        return CLASS_ERROR;
      return CLASS_DATA;
    endfunction

    // Advance the sequence by one accepted frame and queue its result
    function void note_frame(logic [FRAME_W-1:0] f);
      frame_class_t cls;
      result_t      r;
      cls = classify(f);
      if (cls == CLASS_START) seq_pos = 0;
      if (seq_pos == 0) begin
        if (cls != CLASS_START) begin
          r.status = STATUS_REJECT;
        end else begin
          acc = '{default: '0};
          seq_pos = 1;
          r.status = STATUS_BUSY;
        end
      end else if (seq_pos <= SEQ_DATA_FRAMES) begin
        if (cls != CLASS_DATA) begin
          seq_pos = 0;
          r.status = STATUS_REJECT;
        end else begin
          for (int i = 0; i < NUM_SENSOR; i++)
            acc[i][seq_pos-1] = f[SENSOR_A_BIT-i];
          seq_pos++;
          r.status = STATUS_BUSY;
        end
      end else begin
        r.status = (seq_pos == SEQ_DATA_FRAMES + 1 && cls == CLASS_END) ?
                   STATUS_DONE : STATUS_REJECT;
        seq_pos = 0;
      end
      r.frame_class = cls;
      r.sensor_a = acc[0];
      r.sensor_b = acc[1];
      r.sensor_c = acc[2];
      pending_q.push_back(r);
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one output transaction with the oldest expectation
    task check_result(result_t got);
      result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_q.pop_front();
      if (got.status != want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.frame_class != want.frame_class)
        report($sformatf("frame_class got %0d want %0d", got.frame_class, want.frame_class));
      if (got.sensor_a != want.sensor_a)
        report($sformatf("sensor_a got %h want %h", got.sensor_a, want.sensor_a));
      if (got.sensor_b != want.sensor_b)
        report($sformatf("sensor_b got %h want %h", got.sensor_b, want.sensor_b));
      if (got.sensor_c != want.sensor_c)
        report($sformatf("sensor_c got %h want %h", got.sensor_c, want.sensor_c));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [FRAME_W-1:0]     in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  frame_scoreboard sb;
  bit              tx_gaps = 1'b1;
  bit              rx_gaps = 1'b1;
  bit              long_hold = 1'b0;
  int              stall_cycles = 0;

  three_sensor_frame_deframer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Sample both channels at the edge; input first so a frame is queued before its result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_frame(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(result_t'(out_tdata));
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin : rx_side
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Offer one frame and hold it until the transaction completes
  task automatic send_frame(input logic [FRAME_W-1:0] f);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and wait for every result to come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers on consecutive cycles; block must be idle
  task automatic load_config(input logic [CFG_DATA_W-1:0] s, e, m);
    logic [CFG_ADDR_W-1:0] idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx = '{CFG_START_CODE, CFG_END_CODE, CFG_SERVICE_MASK};
    val = '{s, e, m};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Well-formed data frame: parity from the sensor bits, top bits only where unmasked
  function automatic logic [FRAME_W-1:0] data_frame(logic [CFG_DATA_W-1:0] mask);
    logic       a, b, c;
    logic [1:0] top;
    a   = 1'($urandom_range(0, 1));
    b   = 1'($urandom_range(0, 1));
    c   = 1'($urandom_range(0, 1));
    top = 2'($urandom_range(0, 3)) & ~mask[7:6];
    return {top, a, b, c, a ^ b, b ^ c, c ^ a};
  endfunction

  // Mostly full sequences with random content, the rest noise and broken runs
  task automatic random_frames(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) != 0) begin
        send_frame(sb.start_code);
        for (int k = 0; k < SEQ_DATA_FRAMES; k++)
          send_frame($urandom_range(0, 24) == 0 ? 8'($urandom) : data_frame(sb.service_mask));
        case ($urandom_range(0, 7))
          0: send_frame(8'($urandom));
          1: send_frame(data_frame(sb.service_mask));
          default: send_frame(sb.end_code);
        endcase
        sent += SEQ_DATA_FRAMES + 2;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_frame($urandom_range(0, 5) == 0 ? sb.start_code : 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin : main
    logic [FRAME_W-1:0] opening [$];
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: frames before start, a full run to completion, restart, bad parity
    opening = '{8'h00, 8'hFF, END_CODE_RST, START_CODE_RST};
    for (int k = 0; k < SEQ_DATA_FRAMES; k++)
      opening.push_back(k[0] ? 8'h25 : 8'h38);
    opening.push_back(END_CODE_RST);
    opening.push_back(START_CODE_RST);
    opening.push_back(8'h25);
    opening.push_back(START_CODE_RST);
    opening.push_back(8'h38);
    opening.push_back(8'h21);
    opening.push_back(8'h25);
    foreach (opening[i]) send_frame(opening[i]);
    random_frames(350);
    drain();

    // Open codes with no service bits; long receiver hold-off fills the block
    load_config(8'h00, 8'hFF, 8'h00);
    long_hold = 1'b1;
    random_frames(350);
    drain();

    // Equal start and end codes: start always wins
    load_config(8'hA5, 8'hA5, 8'hC0);
    random_frames(150);
    drain();

    // Random register settings
    repeat (3) begin
      load_config(8'($urandom), 8'($urandom),
                  8'($urandom) & ($urandom_range(0, 1) ? 8'hC0 : 8'hFF));
      random_frames(150);
      drain();
    end

    // Every bit masked: nothing can be data
    load_config(8'hFF, 8'h00, 8'hFF);
    random_frames(150);
    drain();

    // Back to reset values at full rate on both sides
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    load_config(START_CODE_RST, END_CODE_RST, SERVICE_MASK_RST);
    random_frames(350);
    drain();
    repeat (10) @(posedge clk);

    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d results never arrived", sb.outstanding()));
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- three_sensor_frame_deframer.f -----
rtl/tsfd_pkg.sv
rtl/tsfd_decode.sv
rtl/three_sensor_frame_deframer.sv
test/three_sensor_frame_deframer_tb.sv
